FILE: hdl/terminal_output_triple_deframer_macros.svh
// Assertion macros shared by the deframer sources.
`ifndef TERMINAL_OUTPUT_TRIPLE_DEFRAMER_MACROS_SVH
`define TERMINAL_OUTPUT_TRIPLE_DEFRAMER_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define TOD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define TOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tod_pkg.sv
// Types, codes and result formatting shared by the deframer modules.
package tod_pkg;

  // Channel commands.
  localparam logic [1:0] CMD_DATA      = 2'd0;
  localparam logic [1:0] CMD_SELECT    = 2'd1;
  localparam logic [1:0] CMD_DESEL_OUT = 2'd2;
  localparam logic [1:0] CMD_DESEL_IN  = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_HELD     = 3'd1;
  localparam logic [2:0] KIND_SYNC_ERR = 3'd2;
  localparam logic [2:0] KIND_IGNORED  = 3'd3;
  localparam logic [2:0] KIND_STATION  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REAL_TIMING  = 2'd0;
  localparam logic [1:0] CFG_FRAME_PERIOD = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Display word codes that change the logged-in flag.
  localparam logic [18:0] WORD_LOGOUT    = 19'd3;
  localparam logic [18:0] WORD_ECHO_TYPE = 19'o0300160;

  // Reset value of the frame period in microseconds.
  localparam logic [19:0] FRAME_PERIOD_RST = 20'd16667;

  // Widest station index carried between modules (up to 64 stations).
  localparam int IDX_MAX_W = 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] data;
    logic [31:0] now_us;
  } tod_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  station;
    logic [18:0] word;
    logic [6:0]  line_byte0;
    logic [7:0]  line_byte1;
    logic [7:0]  line_byte2;
    logic        logged_in;
    logic        last;
  } tod_out_t;

  // Requests from the sequencer to the frame buffer.
  typedef struct packed {
    logic                 wr_en;
    logic [IDX_MAX_W-1:0] wr_idx;
    logic [18:0]          wr_word;
    logic                 li_wr_en;
    logic                 li_val;
    logic                 li_clear_all;
    logic [IDX_MAX_W-1:0] scan_idx;
    logic                 take;
  } fb_req_t;

  // Status from the frame buffer back to the sequencer.
  typedef struct packed {
    logic        any_pend;
    logic        other_pend;
    logic        hit;
    logic        final_one;
    logic        li_wr;
    logic        li_scan;
    logic [18:0] rd_word;
  } fb_sts_t;

  // Builds one result item; line bytes are filled only for station words.
  function automatic tod_out_t make_result(input logic [2:0] kind,
                                           input logic [9:0] stn,
                                           input logic [18:0] w,
                                           input logic bytes,
                                           input logic li,
                                           input logic last);
    tod_out_t r;
    r.kind       = kind;
    r.station    = stn;
    r.word       = w;
    r.line_byte0 = bytes ? w[18:12] : 7'd0;
    r.line_byte1 = bytes ? {2'b10, w[11:6]} : 8'd0;
    r.line_byte2 = bytes ? {2'b11, w[5:0]} : 8'd0;
    r.logged_in  = li;
    r.last       = last;
    return r;
  endfunction

endpackage

FILE: hdl/tod_fbuf.sv
// Per-station frame buffer: pending-word memory, pending bits and login flags.
module tod_fbuf #(
  parameter int STATIONS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tod_pkg::fb_req_t req,
  output tod_pkg::fb_sts_t sts
);
  import tod_pkg::*;

  localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

  logic [18:0]         mem [STATIONS];
  logic [18:0]         rd_word_r;
  logic [STATIONS-1:0] pend_r;
  logic [STATIONS-1:0] pend_nxt;
  logic [STATIONS-1:0] login_r;
  logic [STATIONS-1:0] login_nxt;
  logic [STATIONS-1:0] scan_oh;
  logic [STATIONS-1:0] wr_oh;
  logic [IDX_W-1:0]    wa;
  logic [IDX_W-1:0]    sa;

  assign wa = req.wr_idx[IDX_W-1:0];
  assign sa = req.scan_idx[IDX_W-1:0];

  // One-hot decodes of the write and scan addresses.
  always_comb begin
    for (int i = 0; i < STATIONS; i++) begin
      scan_oh[i] = (sa == IDX_W'(i));
      wr_oh[i]   = (wa == IDX_W'(i));
    end
  end

  // Pending bits mark entries holding a nonzero word; login flags per station.
  always_comb begin
    pend_nxt  = pend_r;
    login_nxt = login_r;
    for (int i = 0; i < STATIONS; i++) begin
      if (req.wr_en && wr_oh[i]) begin
        pend_nxt[i] = (req.wr_word != 19'd0);
      end
      if (req.take && scan_oh[i]) begin
        pend_nxt[i] = 1'b0;
      end
      if (req.li_clear_all) begin
        login_nxt[i] = 1'b0;
      end else if (req.li_wr_en && wr_oh[i]) begin
        login_nxt[i] = req.li_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      login_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      login_r <= login_nxt;
    end
  end

  // Pending-word memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_word;
    end
    if (req.take) begin
      rd_word_r <= mem[sa];
    end
  end

  // Status toward the sequencer.
  always_comb begin
    sts.any_pend   = |pend_r;
    sts.other_pend = |(pend_r & ~wr_oh);
    sts.hit        = |(pend_r & scan_oh);
    sts.final_one  = ((pend_r & ~scan_oh) == '0);
    sts.li_wr      = |(login_r & wr_oh);
    sts.li_scan    = |(login_r & scan_oh);
    sts.rd_word    = rd_word_r;
  end

endmodule

FILE: hdl/terminal_output_triple_deframer.sv
// Top level of the terminal output triple deframer: sequencer and result register.
//
// Each accepted transfer is executed in the EXEC state by a small sequencer; its
// result is held in a result register and moved to the output register in the PUT
// state once the output slot is free, and the block is ready again unless a flush follows.
// A triple that ends a frame then walks the pending-word memory with one scan counter,
// skipping empty entries one per cycle, and reads and sends each pending entry through
// the single memory read port, waiting while the output side stalls. Pending bits and
// login flags clear at reset, and a stored word is read only while its pending bit is
// set, so no clearing pass is needed. The block takes a new input transfer while a
// finished result still waits at the output.
`include "terminal_output_triple_deframer_macros.svh"

module terminal_output_triple_deframer #(
  parameter int STATIONS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tod_pkg::tod_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tod_pkg::tod_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [tod_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tod_pkg::*;

  localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  tod_in_t     in_r, in_nxt;
  tod_out_t    res_r, res_nxt;
  tod_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        flush_r, flush_nxt;
  logic        rt_r, rt_nxt;
  logic [19:0] period_r, period_nxt;
  logic        sel_r, sel_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [18:0] aw_r, aw_nxt;
  logic        fs_r, fs_nxt;
  logic [31:0] lft_r, lft_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [9:0]  emit_stn_r, emit_stn_nxt;
  logic        emit_li_r, emit_li_nxt;
  logic        emit_last_r, emit_last_nxt;

  fb_req_t     fb_req;
  fb_sts_t     fb_sts;

  logic [11:0] d;
  logic [9:0]  stn;
  logic [9:0]  stn_m1;
  logic        in_range;
  logic [31:0] elapsed;
  logic        held;
  logic        fs_after;
  logic        li_new;
  logic        slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  // Field decode of the captured word and the pacing compare.
  assign d        = in_r.data;
  assign stn      = d[9:0];
  assign stn_m1   = stn - 10'd1;
  assign in_range = (stn != 10'd0) && (stn <= 10'(STATIONS));
  assign elapsed  = in_r.now_us - lft_r;
  assign held     = rt_r && fs_r && (elapsed < {12'd0, period_r});

  tod_fbuf #(
    .STATIONS(STATIONS)
  ) u_fbuf (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (fb_req),
    .sts  (fb_sts)
  );

  // Sequencer: execute one command, deliver its result, then scan on frame end.
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    flush_nxt     = flush_r;
    rt_nxt        = rt_r;
    period_nxt    = period_r;
    sel_nxt       = sel_r;
    phase_nxt     = phase_r;
    aw_nxt        = aw_r;
    fs_nxt        = fs_r;
    lft_nxt       = lft_r;
    scan_nxt      = scan_r;
    emit_stn_nxt  = emit_stn_r;
    emit_li_nxt   = emit_li_r;
    emit_last_nxt = emit_last_r;
    fs_after      = fs_r | d[10];
    li_new        = 1'b0;

    fb_req          = '0;
    fb_req.wr_idx   = stn_m1[IDX_MAX_W-1:0];
    fb_req.wr_word  = aw_r;
    fb_req.scan_idx = IDX_MAX_W'(scan_r);

    // The output register drains whenever its transfer completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_idx)
        CFG_REAL_TIMING:  rt_nxt = cfg_wdata[0];
        CFG_FRAME_PERIOD: period_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt   = make_result(KIND_ACCEPTED, 10'd0, 19'd0, 1'b0, 1'b0, 1'b1);
        flush_nxt = 1'b0;
        state_nxt = ST_PUT;
        case (in_r.cmd)
          CMD_SELECT: begin
            sel_nxt   = 1'b1;
            phase_nxt = 2'd0;
          end
          CMD_DESEL_OUT: begin
            sel_nxt = 1'b0;
          end
          CMD_DESEL_IN: begin
            fb_req.li_clear_all = 1'b1;
          end
          default: begin
            if (!sel_r) begin
              res_nxt.kind = KIND_IGNORED;
            end else if (phase_r == 2'd0) begin
              // First position: pacing check, then sync check.
              if (held) begin
                res_nxt.kind = KIND_HELD;
              end else begin
                if (rt_r && fs_r) begin
                  lft_nxt = in_r.now_us;
                end
                fs_nxt = 1'b0;
                if (d[11:10] != 2'b10) begin
                  res_nxt.kind = KIND_SYNC_ERR;
                end else begin
                  aw_nxt    = {d[9:0], 9'd0};
                  phase_nxt = 2'd1;
                end
              end
            end else if (phase_r == 2'd1) begin
              // Second position: low half of the display word.
              if ((d[11:10] != 2'b00) || d[0]) begin
                res_nxt.kind = KIND_SYNC_ERR;
              end else begin
                aw_nxt    = aw_r | {8'd0, d[11:1]};
                phase_nxt = 2'd2;
              end
            end else begin
              // Third position: station address and frame-end mark.
              if (d[11]) begin
                res_nxt.kind = KIND_SYNC_ERR;
              end else begin
                fs_nxt    = fs_after;
                phase_nxt = 2'd0;
                if (in_range) begin
                  fb_req.wr_en    = 1'b1;
                  fb_req.li_wr_en = (aw_r == WORD_LOGOUT) || (aw_r == WORD_ECHO_TYPE);
                  fb_req.li_val   = (aw_r == WORD_ECHO_TYPE);
                  li_new          = fb_req.li_wr_en ? fb_req.li_val : fb_sts.li_wr;
                end
                // A stored zero word clears that station, so only the others count.
                flush_nxt = fs_after &&
                            (in_range ? (fb_sts.other_pend || (aw_r != 19'd0))
                                      : fb_sts.any_pend);
                res_nxt   = make_result(KIND_ACCEPTED, 10'd0, aw_r, 1'b0, li_new,
                                        !flush_nxt);
              end
            end
          end
        endcase
      end

      ST_PUT: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          scan_nxt      = '0;
          state_nxt     = flush_r ? ST_SCAN : ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Skip empty entries; take a pending one out of the memory.
        if (fb_sts.hit) begin
          fb_req.take   = 1'b1;
          emit_stn_nxt  = 10'(scan_r) + 10'd1;
          emit_li_nxt   = fb_sts.li_scan;
          emit_last_nxt = fb_sts.final_one;
          state_nxt     = ST_EMIT;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_nxt       = make_result(KIND_STATION, emit_stn_r, fb_sts.rd_word, 1'b1,
                                      emit_li_r, emit_last_r);
          out_valid_nxt = 1'b1;
          if (emit_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            scan_nxt  = scan_r + IDX_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
      rt_r        <= 1'b0;
      period_r    <= FRAME_PERIOD_RST;
      sel_r       <= 1'b0;
      phase_r     <= 2'd0;
      aw_r        <= 19'd0;
      fs_r        <= 1'b0;
      lft_r       <= 32'd0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      flush_r     <= flush_nxt;
      rt_r        <= rt_nxt;
      period_r    <= period_nxt;
      sel_r       <= sel_nxt;
      phase_r     <= phase_nxt;
      aw_r        <= aw_nxt;
      fs_r        <= fs_nxt;
      lft_r       <= lft_nxt;
      scan_r      <= scan_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    emit_stn_r  <= emit_stn_nxt;
    emit_li_r   <= emit_li_nxt;
    emit_last_r <= emit_last_nxt;
  end

  // A frame scan only runs while some station word is still pending.
  `TOD_ASSERT_SAME(a_scan_has_work, (state_r == ST_SCAN), fb_sts.any_pend, "scan with empty buffer")
  // A non-final result keeps the block busy until the frame is drained.
  `TOD_ASSERT_SAME(a_busy_until_last, (out_valid_r && !out_r.last), (state_r == ST_SCAN || state_r == ST_EMIT), "idle before last result")
  // Station words name a real station and carry a nonzero word.
  `TOD_ASSERT_SAME(a_station_word_ok, (out_valid_r && out_r.kind == KIND_STATION), (out_r.station != 10'd0 && out_r.word != 19'd0), "bad station word")
  // An accepted input is executed in the following cycle.
  `TOD_ASSERT_NEXT(a_accept_exec, (in_valid && in_ready), (state_r == ST_EXEC), "accepted input not executed")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the terminal output triple deframer.
`timescale 1ns / 1ps

module tb_top;
  import tod_pkg::*;

  localparam int STATIONS = 32;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS = 40;

  // Register indexes the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} chan_op_e;
  typedef enum logic [1:0] {FLAW_NONE, FLAW_NOISE, FLAW_DROP, FLAW_CUT} flaw_e;

  typedef struct {
    chan_op_e              op;
    tod_in_t               item;
    int unsigned           gap;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } chan_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tod_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tod_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  terminal_output_triple_deframer #(.STATIONS(STATIONS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mirror of the block's configuration and deframing state.
  logic                  pace_on;
  logic [19:0]           period_us;
  logic                  out_selected;
  logic [1:0]            trip_pos;
  logic [18:0]           disp_word;
  logic                  frame_mark;
  logic [31:0]           last_frame_us;
  logic [18:0]           pend_word [STATIONS];
  logic                  station_login [STATIONS];

  // Expected results in arrival order, and the transfers that produced them.
  tod_out_t    due_results[$];
  tod_out_t    step_results[$];
  chan_op_t    chan_ops[$];
  int unsigned n_results_due = 0;
  int unsigned n_results_seen = 0;
  int unsigned n_items_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned kind_count [8];
  logic        stim_done = 1'b0;

  // Stimulus generation state.
  logic [31:0] gen_us = '0;
  int unsigned gen_step = 0;
  bit          gen_rand_now = 1'b1;
  bit          gen_jumps = 1'b0;
  bit          gen_calm = 1'b0;
  int unsigned gen_items = 0;

  function automatic tod_out_t build_result(input logic [2:0] kind, input logic [9:0] stn,
                                            input logic [18:0] w, input logic bytes,
                                            input logic li);
    tod_out_t r;
    r.kind       = kind;
    r.station    = stn;
    r.word       = w;
    r.line_byte0 = bytes ? w[18:12] : '0;
    r.line_byte1 = bytes ? {2'b10, w[11:6]} : '0;
    r.line_byte2 = bytes ? {2'b11, w[5:0]} : '0;
    r.logged_in  = li;
    r.last       = 1'b0;
    return r;
  endfunction

  // Works out every result one accepted transfer causes and queues them.
  task automatic deframe_predict(input tod_in_t it);
    logic [9:0] stn;
    logic       li;
    int         i;
    step_results = {};
    case (it.cmd)
      CMD_SELECT: begin
        out_selected = 1'b1;
        trip_pos = 2'd0;
        step_results.push_back(build_result(KIND_ACCEPTED, '0, '0, 1'b0, 1'b0));
      end
      CMD_DESEL_OUT: begin
        out_selected = 1'b0;
        step_results.push_back(build_result(KIND_ACCEPTED, '0, '0, 1'b0, 1'b0));
      end
      CMD_DESEL_IN: begin
        for (i = 0; i < STATIONS; i++) station_login[i] = 1'b0;
        step_results.push_back(build_result(KIND_ACCEPTED, '0, '0, 1'b0, 1'b0));
      end
      default: begin
        if (!out_selected) begin
          step_results.push_back(build_result(KIND_IGNORED, '0, '0, 1'b0, 1'b0));
        end else if (trip_pos == 2'd0) begin
          // First position: optional frame pacing, then the sync check.
          if (pace_on && frame_mark && ((it.now_us - last_frame_us) < {12'd0, period_us})) begin
            step_results.push_back(build_result(KIND_HELD, '0, '0, 1'b0, 1'b0));
          end else begin
            if (pace_on && frame_mark) last_frame_us = it.now_us;
            frame_mark = 1'b0;
            if (it.data[11:10] != 2'b10) begin
              step_results.push_back(build_result(KIND_SYNC_ERR, '0, '0, 1'b0, 1'b0));
            end else begin
              disp_word = {it.data[9:0], 9'd0};
              trip_pos = 2'd1;
              step_results.push_back(build_result(KIND_ACCEPTED, '0, '0, 1'b0, 1'b0));
            end
          end
        end else if (trip_pos == 2'd1) begin
          if (it.data[11:10] != 2'b00 || it.data[0]) begin
            step_results.push_back(build_result(KIND_SYNC_ERR, '0, '0, 1'b0, 1'b0));
          end else begin
            disp_word = disp_word | {8'd0, it.data[11:1]};
            trip_pos = 2'd2;
            step_results.push_back(build_result(KIND_ACCEPTED, '0, '0, 1'b0, 1'b0));
          end
        end else if (it.data[11]) begin
          step_results.push_back(build_result(KIND_SYNC_ERR, '0, '0, 1'b0, 1'b0));
        end else begin
          // Third position: store the word for its station, then flush at frame end.
          stn = it.data[9:0];
          li = 1'b0;
          if (it.data[10]) frame_mark = 1'b1;
          if (stn >= 10'd1 && stn <= 10'(STATIONS)) begin
            pend_word[stn - 1] = disp_word;
            if (disp_word == WORD_LOGOUT) station_login[stn - 1] = 1'b0;
            else if (disp_word == WORD_ECHO_TYPE) station_login[stn - 1] = 1'b1;
            li = station_login[stn - 1];
          end
          step_results.push_back(build_result(KIND_ACCEPTED, '0, disp_word, 1'b0, li));
          trip_pos = 2'd0;
          if (frame_mark) begin
            for (i = 0; i < STATIONS; i++) begin
              if (pend_word[i] != '0) begin
                step_results.push_back(build_result(KIND_STATION, 10'(i + 1), pend_word[i],
                                                    1'b1, station_login[i]));
                pend_word[i] = '0;
              end
            end
          end
        end
      end
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) due_results.push_back(step_results[i]);
    n_results_due += step_results.size();
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic add_item(input logic [1:0] cmd, input logic [11:0] data);
    chan_op_t op;
    if (gen_rand_now) begin
      gen_us = $urandom();
    end else begin
      gen_us = gen_us + $urandom_range(0, gen_step);
      if (gen_jumps && $urandom_range(0, 15) == 0)
        gen_us = gen_us + $urandom_range(32'h10_0000, 32'h20_0000);
    end
    op.op = OP_ITEM;
    op.item.cmd = cmd;
    op.item.data = data;
    op.item.now_us = gen_us;
    op.gap = gen_calm ? 0 : $urandom_range(0, 13);
    op.reg_idx = '0;
    op.reg_val = '0;
    chan_ops.push_back(op);
    gen_items++;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    chan_op_t op;
    op.op = OP_CFG;
    op.item = '0;
    op.gap = 0;
    op.reg_idx = idx;
    op.reg_val = val;
    chan_ops.push_back(op);
  endtask

  task automatic add_drain();
    chan_op_t op;
    op.op = OP_DRAIN;
    op.item = '0;
    op.gap = 0;
    op.reg_idx = '0;
    op.reg_val = '0;
    chan_ops.push_back(op);
  endtask

  // One triple, optionally with a noisy, missing or cut-off position.
  task automatic add_triple(input logic [18:0] w, input logic [9:0] stn, input logic fe,
                            input int unsigned reps, input flaw_e flaw, input int unsigned pos);
    logic [11:0] tw [3];
    int unsigned i;
    tw[0] = {2'b10, w[18:9]};
    tw[1] = {2'b00, w[8:0], 1'b0};
    tw[2] = {1'b0, fe, stn};
    for (i = 0; i < 3; i++) begin
      if (flaw == FLAW_CUT && i == pos) begin
        add_item(CMD_SELECT, 12'($urandom_range(0, 12'hFFF)));
        break;
      end
      if (flaw == FLAW_DROP && i == pos) continue;
      if (flaw == FLAW_NOISE && i == pos) add_item(CMD_DATA, 12'($urandom_range(0, 12'hFFF)));
      else if (i == 0) repeat (reps) add_item(CMD_DATA, tw[0]);
      else add_item(CMD_DATA, tw[i]);
    end
  endtask

  // Mostly well-formed triples with random content, plus noise and commands.
  task automatic add_random_phase(input int unsigned n_items, input bit paced);
    int unsigned start;
    int unsigned pick;
    int unsigned reps;
    logic [18:0] w;
    logic [9:0]  stn;
    logic        fe;
    start = gen_items;
    while (gen_items - start < n_items) begin
      if ($urandom_range(0, 19) == 0) gen_calm = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0, 1: w = WORD_LOGOUT;
        2, 3: w = WORD_ECHO_TYPE;
        4: w = '0;
        5: w = '1;
        default: w = 19'($urandom_range(0, 19'h7FFFF));
      endcase
      case ($urandom_range(0, 24))
        0, 1: stn = '0;
        2, 3, 4: stn = 10'($urandom_range(STATIONS + 1, 1023));
        default: stn = 10'($urandom_range(1, STATIONS));
      endcase
      fe = ($urandom_range(0, 3) == 0);
      reps = paced ? $urandom_range(1, 4) : 1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_triple(w, stn, fe, reps, FLAW_NONE, 0);
      end else if (pick < 72) begin
        add_triple(w, stn, fe, reps, $urandom_range(0, 1) ? FLAW_NOISE : FLAW_DROP,
                   $urandom_range(0, 2));
      end else if (pick < 77) begin
        add_triple(w, stn, fe, reps, FLAW_CUT, $urandom_range(1, 2));
      end else if (pick < 84) begin
        add_item(CMD_DATA, 12'($urandom_range(0, 12'hFFF)));
      end else if (pick < 90) begin
        add_item($urandom_range(0, 1) ? CMD_SELECT : CMD_DESEL_IN,
                 12'($urandom_range(0, 12'hFFF)));
      end else if (pick < 94) begin
        add_item(CMD_DESEL_OUT, 12'($urandom_range(0, 12'hFFF)));
        repeat ($urandom_range(1, 3)) add_item(CMD_DATA, 12'($urandom_range(0, 12'hFFF)));
        add_item(CMD_SELECT, 12'($urandom_range(0, 12'hFFF)));
      end else if (pick < 97) begin
        add_drain();
      end else begin
        add_item(2'($urandom_range(0, 3)), 12'($urandom_range(0, 12'hFFF)));
      end
    end
  endtask

  // Driver: presents queued transfers and register writes.
  always @(posedge clk) begin : driver
    tod_in_t               nxt_data;
    logic                  nxt_valid;
    logic                  nxt_we;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_wdata;
    int unsigned           gap_cnt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      gap_cnt = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      nxt_we = 1'b0;
      nxt_idx = cfg_idx;
      nxt_wdata = cfg_wdata;
      if (in_valid && in_ready) begin
        deframe_predict(in_data);
        n_items_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && chan_ops.size() > 0) begin
        if (gap_cnt < chan_ops[0].gap) begin
          gap_cnt++;
        end else begin
          case (chan_ops[0].op)
            OP_ITEM: begin
              nxt_valid = 1'b1;
              nxt_data = chan_ops[0].item;
              void'(chan_ops.pop_front());
              gap_cnt = 0;
            end
            OP_CFG: begin
              // Registers change only once every result is out.
              if (n_results_due == n_results_seen) begin
                nxt_we = 1'b1;
                nxt_idx = chan_ops[0].reg_idx;
                nxt_wdata = chan_ops[0].reg_val;
                case (chan_ops[0].reg_idx)
                  CFG_REAL_TIMING: pace_on = chan_ops[0].reg_val[0];
                  CFG_FRAME_PERIOD: period_us = chan_ops[0].reg_val;
                  default: ;
                endcase
                void'(chan_ops.pop_front());
              end
            end
            default: begin
              if (n_results_due == n_results_seen) void'(chan_ops.pop_front());
            end
          endcase
        end
      end
      if (!nxt_valid && chan_ops.size() == 0) stim_done <= 1'b1;
      in_valid <= nxt_valid;
      in_data <= nxt_data;
      cfg_we <= nxt_we;
      cfg_idx <= nxt_idx;
      cfg_wdata <= nxt_wdata;
    end
  end

  // Monitor: checks each result transfer and stalls the output at random.
  always @(posedge clk) begin : monitor
    tod_out_t    want;
    int unsigned stall_cnt;
    int unsigned seen_cnt;
    bit          rx_calm;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt = 0;
      seen_cnt = 0;
      rx_calm = 1'b0;
    end else if (out_valid && out_ready) begin
      kind_count[out_data.kind]++;
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result mismatch, expected none, actual kind %0d station %0d word 0x%0h",
                   $time, out_data.kind, out_data.station, out_data.word);
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("station", want.station, out_data.station);
        check_field("word", want.word, out_data.word);
        check_field("line_byte0", want.line_byte0, out_data.line_byte0);
        check_field("line_byte1", want.line_byte1, out_data.line_byte1);
        check_field("line_byte2", want.line_byte2, out_data.line_byte2);
        check_field("logged_in", want.logged_in, out_data.logged_in);
        check_field("last", want.last, out_data.last);
        n_results_seen <= n_results_seen + 1;
      end
      seen_cnt++;
      if (seen_cnt % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall_cnt = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall_cnt > 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (stall_cnt == 0) out_ready <= 1'b1;
      else stall_cnt--;
    end
  end

  // Cycle limit.
  int unsigned cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // Model state after reset.
    pace_on = 1'b0;
    period_us = FRAME_PERIOD_RST;
    out_selected = 1'b0;
    trip_pos = 2'd0;
    disp_word = '0;
    frame_mark = 1'b0;
    last_frame_us = '0;
    foreach (pend_word[i]) begin
      pend_word[i] = '0;
      station_login[i] = 1'b0;
    end
    foreach (kind_count[i]) kind_count[i] = 0;

    // Directed: commands, sync checks at every position, login codes, flush.
    add_item(CMD_DATA, 12'o7777);
    add_item(CMD_DESEL_IN, 12'o0000);
    add_item(CMD_SELECT, 12'o0000);
    add_item(CMD_DATA, 12'o0000);
    add_item(CMD_DATA, 12'o7777);
    add_item(CMD_DATA, 12'o5777);
    add_item(CMD_DATA, 12'o0001);
    add_item(CMD_DATA, 12'o6000);
    add_item(CMD_DATA, 12'o1776);
    add_item(CMD_DATA, 12'o4000);
    add_item(CMD_DATA, 12'o0005);
    add_triple(WORD_ECHO_TYPE, 10'(STATIONS), 1'b0, 1, FLAW_NONE, 0);
    add_triple(WORD_ECHO_TYPE, 10'd1, 1'b0, 1, FLAW_NONE, 0);
    add_triple(WORD_LOGOUT, 10'd1, 1'b0, 1, FLAW_NONE, 0);
    add_triple(19'h12345, 10'd0, 1'b1, 1, FLAW_NONE, 0);
    add_triple(19'h00001, 10'd1023, 1'b0, 1, FLAW_NONE, 0);
    add_triple(19'h2AAAA, 10'd7, 1'b0, 1, FLAW_CUT, 1);
    add_item(CMD_DESEL_IN, 12'o7777);
    add_item(CMD_DESEL_OUT, 12'o0000);
    add_item(CMD_DATA, 12'o4001);
    add_item(CMD_SELECT, 12'o0000);

    // Directed pacing: a held first word, then one that passes and fails sync.
    gen_rand_now = 1'b0;
    gen_step = 0;
    add_cfg(CFG_FRAME_PERIOD, 20'd100);
    add_cfg(CFG_REAL_TIMING, 20'd1);
    gen_us = 32'd1000;
    add_triple(19'h0A0A0, 10'd3, 1'b1, 1, FLAW_NONE, 0);
    add_triple(19'h2A5A5, 10'd4, 1'b1, 1, FLAW_NONE, 0);
    gen_us = 32'd1050;
    add_item(CMD_DATA, 12'o4001);
    gen_us = 32'd1100;
    add_item(CMD_DATA, 12'o7777);
    add_triple(19'h0F0F0, 10'd5, 1'b0, 1, FLAW_NONE, 0);
    add_drain();

    // Random phases over the range of both registers.
    gen_rand_now = 1'b1;
    add_cfg(CFG_REAL_TIMING, 20'd0);
    add_cfg(CFG_FRAME_PERIOD, 20'($urandom_range(0, 1000000)));
    add_random_phase(48, 1'b0);

    gen_rand_now = 1'b0;
    gen_step = 15;
    add_cfg(CFG_REAL_TIMING, 20'd1);
    add_cfg(CFG_FRAME_PERIOD, 20'd0);
    add_random_phase(48, 1'b1);

    add_cfg(CFG_FRAME_PERIOD, 20'($urandom_range(1, 40)));
    add_random_phase(48, 1'b1);

    // Largest period the register holds, with time wrapping through zero.
    gen_us = 32'hFFFF_FF00;
    gen_jumps = 1'b1;
    add_cfg(CFG_SPARE_A, 20'hFFFFF);
    add_cfg(CFG_SPARE_B, 20'h00000);
    add_cfg(CFG_FRAME_PERIOD, 20'hFFFFF);
    add_random_phase(48, 1'b1);

    add_cfg(CFG_FRAME_PERIOD, 20'd1000000);
    add_random_phase(48, 1'b1);

    // Only bit 0 of the timing register counts.
    gen_jumps = 1'b0;
    gen_rand_now = 1'b1;
    add_cfg(CFG_REAL_TIMING, 20'hFFFFE);
    add_cfg(CFG_FRAME_PERIOD, FRAME_PERIOD_RST);
    add_random_phase(48, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all transfers and results, then for a frame flush worth of cycles.
    while (!(stim_done && n_results_due == n_results_seen)) @(negedge clk);
    repeat (2 * STATIONS + 8) @(posedge clk);
    if (due_results.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end

    $display("Sent %0d input transfers and checked %0d results (%0d station words,",
             n_items_sent, n_results_seen, kind_count[KIND_STATION]);
    $display("  %0d pacing holds, %0d sync errors, %0d ignored words), %0d mismatches.",
             kind_count[KIND_HELD], kind_count[KIND_SYNC_ERR], kind_count[KIND_IGNORED],
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tod_pkg.sv
hdl/tod_fbuf.sv
hdl/terminal_output_triple_deframer.sv
dv/tb_top.sv
